// ===== hdl/xorshift8_bit_dispenser_top_defines.svh =====
// assertion macros shared by the dispenser rtl
// expects i_clk and i_rst_n in the module that uses them
`ifndef XORSHIFT8_BIT_DISPENSER_TOP_DEFINES_SVH
`define XORSHIFT8_BIT_DISPENSER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define XBD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define XBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/xbd_pkg.sv =====
// shared types, codes and the xorshift step for the bit dispenser
// no dependencies
package xbd_pkg;

    localparam int WORD_W = 8;
    localparam int CNT_W  = 4;

    localparam logic [CNT_W-1:0] FULL_CNT     = 4'd8;
    localparam logic [CNT_W-1:0] MAX_UNSIGNED = 4'd8;
    localparam logic [CNT_W-1:0] MAX_SIGNED   = 4'd7;

    localparam logic [1:0] KIND_SEED     = 2'd0;
    localparam logic [1:0] KIND_UNSIGNED = 2'd1;
    localparam logic [1:0] KIND_SIGNED   = 2'd2;

    localparam logic [1:0] OP_SEED      = 2'd0;
    localparam logic [1:0] OP_UNSIGNED  = 2'd1;
    localparam logic [1:0] OP_SIGNED    = 2'd2;
    localparam logic [1:0] OP_RANGE_ERR = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [CNT_W-1:0]  take;
        logic [WORD_W-1:0] seed;
    } t_cmd;

    function automatic logic [WORD_W-1:0] xorshift_next(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = x ^ (x << 1);
        b = a ^ (a >> 1);
        return b ^ (b >> 2);
    endfunction

endpackage

// ===== hdl/xorshift8_bit_dispenser_top.sv =====
// xorshift8 bit dispenser, top level
// depends on xbd_pkg, xbd_front, xbd_cmd_fifo, xbd_back
//
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------
//  request  | push / full       | i_kind, i_seed_value, i_bit_count
//  result   | pop / empty       | o_value, o_in_range
//
// an accepted request, unless a zero seed or an unused kind, enters the command queue in
// the cycle it is accepted; the sequencer loads a seed directly and serves a draw with up
// to two reserve-to-buffer transfers, then the extract, which waits for a free result slot.
// the reserve data holds no reset value and needs no clearing pass.
// full rises when CMD_DEPTH requests wait; a full result register stalls only the sequencer's extract.
module xorshift8_bit_dispenser_top
    import xbd_pkg::*;
#(
    parameter int CMD_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_kind,
    input  logic [WORD_W-1:0] i_seed_value,
    input  logic [CNT_W-1:0]  i_bit_count,
    output logic              empty,
    input  logic              pop,
    output logic [WORD_W-1:0] o_value,
    output logic              o_in_range
);

    logic w_fifo_full;
    logic w_wr_en;
    t_cmd w_wr_cmd;
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_pop;

    xbd_front u_front (
        .i_push       (push),
        .i_kind       (i_kind),
        .i_seed_value (i_seed_value),
        .i_bit_count  (i_bit_count),
        .i_fifo_full  (w_fifo_full),
        .o_full       (full),
        .o_wr_en      (w_wr_en),
        .o_cmd        (w_wr_cmd)
    );

    xbd_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_data (w_wr_cmd),
        .i_rd_en   (w_cmd_pop),
        .o_full    (w_fifo_full),
        .o_valid   (w_cmd_valid),
        .o_rd_data (w_cmd)
    );

    xbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_value     (o_value),
        .o_in_range  (o_in_range)
    );

endmodule

// ===== hdl/xbd_front.sv =====
// request classifier: turns input requests into queue commands
// depends on xbd_pkg
module xbd_front
    import xbd_pkg::*;
(
    input  logic              i_push,
    input  logic [1:0]        i_kind,
    input  logic [WORD_W-1:0] i_seed_value,
    input  logic [CNT_W-1:0]  i_bit_count,
    input  logic              i_fifo_full,
    output logic              o_full,
    output logic              o_wr_en,
    output t_cmd              o_cmd
);

    logic w_accept;

    assign w_accept = i_push && !i_fifo_full;
    assign o_full   = i_fifo_full;

    always_comb begin
        o_wr_en     = 1'b0;
        o_cmd.op    = OP_RANGE_ERR;
        o_cmd.take  = i_bit_count;
        o_cmd.seed  = i_seed_value;
        unique case (i_kind)
            KIND_SEED: begin
                o_cmd.op = OP_SEED;
                o_wr_en  = w_accept && (i_seed_value != '0);
            end
            KIND_UNSIGNED: begin
                o_wr_en = w_accept;
                if (i_bit_count != '0 && i_bit_count <= MAX_UNSIGNED) begin
                    o_cmd.op = OP_UNSIGNED;
                end
            end
            KIND_SIGNED: begin
                o_wr_en = w_accept;
                if (i_bit_count != '0 && i_bit_count <= MAX_SIGNED) begin
                    o_cmd.op   = OP_SIGNED;
                    o_cmd.take = i_bit_count + 4'd1;
                end
            end
            default: begin
                // unused kind is dropped
                o_wr_en = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/xbd_cmd_fifo.sv =====
// small command queue between classifier and sequencer
// depends on xbd_pkg
module xbd_cmd_fifo
    import xbd_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_en,
    input  t_cmd i_wr_data,
    input  logic i_rd_en,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W_Q-1:0] DEPTH_CNT = CNT_W_Q'(DEPTH);

    t_cmd               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W_Q-1:0] r_cnt, n_cnt;
    logic               w_wr;
    logic               w_rd;

    assign o_full    = (r_cnt == DEPTH_CNT);
    assign o_valid   = (r_cnt != '0);
    assign o_rd_data = r_mem[r_rptr];
    assign w_wr      = i_wr_en && !o_full;
    assign w_rd      = i_rd_en && o_valid;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_wr) begin
            n_wptr = (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end

endmodule

// ===== hdl/xbd_back.sv =====
// sequencer: generator, reserve and buffer, plus the result register
// depends on xbd_pkg and the assertion macro header
`include "xorshift8_bit_dispenser_top_defines.svh"

module xbd_back
    import xbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [WORD_W-1:0] o_value,
    output logic              o_in_range
);

    logic [WORD_W-1:0] r_gen, n_gen;
    logic [WORD_W-1:0] r_buf, n_buf;
    logic [CNT_W-1:0]  r_bcnt, n_bcnt;
    logic [WORD_W-1:0] r_res, n_res;
    logic [CNT_W-1:0]  r_rcnt, n_rcnt;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_value, n_out_value;
    logic              r_out_in_range, n_out_in_range;

    logic              w_slot_free;
    logic              w_xfer;
    logic              w_emit;
    logic [WORD_W-1:0] w_next_gen;
    logic [WORD_W-1:0] w_src;
    logic [CNT_W-1:0]  w_scnt;
    logic [CNT_W-1:0]  w_room;
    logic [CNT_W-1:0]  w_moved;
    logic [WORD_W-1:0] w_mask;
    logic [WORD_W-1:0] w_bits;
    logic [2:0]        w_sign_idx;
    logic [WORD_W-1:0] w_signed_val;

    assign w_slot_free = !r_out_valid || i_pop;

    // refill from the generator when the reserve is empty
    assign w_next_gen = xorshift_next(r_gen);
    assign w_src      = (r_rcnt == '0) ? w_next_gen : r_res;
    assign w_scnt     = (r_rcnt == '0) ? FULL_CNT : r_rcnt;
    assign w_room     = FULL_CNT - r_bcnt;
    assign w_moved    = (w_scnt >= w_room) ? w_room : w_scnt;

    // low bits out of the buffer
    assign w_mask       = 8'hFF >> (FULL_CNT - i_cmd.take);
    assign w_bits       = r_buf & w_mask;
    assign w_sign_idx   = 3'(i_cmd.take - 4'd1);
    assign w_signed_val = w_bits[w_sign_idx] ? (w_bits | (8'hFF << w_sign_idx)) : w_bits;

    always_comb begin
        n_gen          = r_gen;
        n_buf          = r_buf;
        n_bcnt         = r_bcnt;
        n_res          = r_res;
        n_rcnt         = r_rcnt;
        n_out_valid    = r_out_valid && !i_pop;
        n_out_value    = r_out_value;
        n_out_in_range = r_out_in_range;
        o_cmd_pop      = 1'b0;
        w_xfer         = 1'b0;
        w_emit         = 1'b0;
        if (i_cmd_valid) begin
            unique case (i_cmd.op) inside
                OP_SEED: begin
                    n_gen     = i_cmd.seed;
                    o_cmd_pop = 1'b1;
                end
                OP_RANGE_ERR: begin
                    if (w_slot_free) begin
                        w_emit         = 1'b1;
                        o_cmd_pop      = 1'b1;
                        n_out_valid    = 1'b1;
                        n_out_value    = '0;
                        n_out_in_range = 1'b0;
                    end
                end
                OP_UNSIGNED, OP_SIGNED: begin
                    if (r_bcnt < i_cmd.take) begin
                        w_xfer = 1'b1;
                        if (r_rcnt == '0) begin
                            n_gen = w_next_gen;
                        end
                        n_buf  = r_buf | (w_src << r_bcnt[2:0]);
                        n_bcnt = r_bcnt + w_moved;
                        n_res  = w_src >> w_moved;
                        n_rcnt = w_scnt - w_moved;
                    end else if (w_slot_free) begin
                        w_emit         = 1'b1;
                        o_cmd_pop      = 1'b1;
                        n_buf          = r_buf >> i_cmd.take;
                        n_bcnt         = r_bcnt - i_cmd.take;
                        n_out_valid    = 1'b1;
                        n_out_value    = (i_cmd.op == OP_SIGNED) ? w_signed_val : w_bits;
                        n_out_in_range = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen       <= 8'd1;
            r_buf       <= '0;
            r_bcnt      <= '0;
            r_rcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_gen       <= n_gen;
            r_buf       <= n_buf;
            r_bcnt      <= n_bcnt;
            r_rcnt      <= n_rcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res          <= n_res;
        r_out_value    <= n_out_value;
        r_out_in_range <= n_out_in_range;
    end

    assign o_empty    = !r_out_valid;
    assign o_value    = r_out_value;
    assign o_in_range = r_out_in_range;

    `XBD_ASSERT_NOW(a_bcnt_max, 1'b1, r_bcnt <= FULL_CNT && r_rcnt <= FULL_CNT, "count above 8")
    `XBD_ASSERT_NOW(a_buf_clean, 1'b1, (r_buf >> r_bcnt) == '0, "buffer bits above count")
    `XBD_ASSERT_NEXT(a_xfer_grows, w_xfer, r_bcnt > $past(r_bcnt), "transfer moved no bits")
    `XBD_ASSERT_NOW(a_emit_excl, w_emit, !w_xfer && w_slot_free, "result without free slot")

endmodule

// ===== tb/sv/tb_xorshift8_bit_dispenser_top.sv =====
// testbench for xorshift8_bit_dispenser_top: directed corners, then seeded draw streams
// and random mixes, each draw checked against an in-bench generator and dispenser model
// depends on xbd_pkg and the dispenser rtl
module tb_xorshift8_bit_dispenser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import xbd_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTS = 20;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              in_range;
    } t_draw;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [1:0]        i_kind = KIND_SEED;
    logic [WORD_W-1:0] i_seed_value = '0;
    logic [CNT_W-1:0]  i_bit_count = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [WORD_W-1:0] o_value;
    logic              o_in_range;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count = 0;
    int request_count = 0;
    int draw_count = 0;
    int seed_count = 0;
    int range_err_count = 0;
    int checked_count = 0;

    t_draw pending_draws[$];

    // dispenser state as seen by the bench
    logic [WORD_W-1:0] gen_state = 8'd1;
    logic [WORD_W-1:0] buf_bits = '0;
    int                buf_cnt = 0;
    logic [WORD_W-1:0] rsv_bits = '0;
    int                rsv_cnt = 0;

    xorshift8_bit_dispenser_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_kind       (i_kind),
        .i_seed_value (i_seed_value),
        .i_bit_count  (i_bit_count),
        .empty        (empty),
        .pop          (pop),
        .o_value      (o_value),
        .o_in_range   (o_in_range)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d draws still outstanding", pending_draws.size());
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [WORD_W-1:0] take_bits(input int n);
        int                room;
        int                moved;
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] bits;
        while (buf_cnt < n) begin
            if (rsv_cnt == 0) begin
                x = gen_state;
                x = x ^ {x[6:0], 1'b0};
                x = x ^ {1'b0, x[7:1]};
                x = x ^ {2'b00, x[7:2]};
                gen_state = x;
                rsv_bits = x;
                rsv_cnt = 8;
            end
            room = 8 - buf_cnt;
            moved = (rsv_cnt >= room) ? room : rsv_cnt;
            buf_bits = buf_bits | (rsv_bits << buf_cnt);
            buf_cnt += moved;
            rsv_bits = (moved >= 8) ? '0 : rsv_bits >> moved;
            rsv_cnt -= moved;
        end
        bits = buf_bits & (8'hFF >> (8 - n));
        buf_bits = (n >= 8) ? '0 : buf_bits >> n;
        buf_cnt -= n;
        return bits;
    endfunction

    task automatic predict_request(input logic [1:0] kind, input logic [WORD_W-1:0] seed,
                                   input logic [CNT_W-1:0] cnt);
        t_draw             d;
        logic [WORD_W-1:0] v;
        int                n;
        n = int'(cnt);
        d = '0;
        case (kind)
            KIND_SEED: begin
                if (seed != 0)
                    gen_state = seed;
                seed_count++;
            end
            KIND_UNSIGNED, KIND_SIGNED: begin
                if (kind == KIND_UNSIGNED && n >= 1 && n <= int'(MAX_UNSIGNED)) begin
                    d.value = take_bits(n);
                    d.in_range = 1'b1;
                end else if (kind == KIND_SIGNED && n >= 1 && n <= int'(MAX_SIGNED)) begin
                    v = take_bits(n + 1);
                    if (v[n])
                        v = v | (8'hFF << n);
                    d.value = v;
                    d.in_range = 1'b1;
                end else begin
                    range_err_count++;
                end
                pending_draws.push_back(d);
                draw_count++;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_request(input logic [1:0] kind, input logic [WORD_W-1:0] seed,
                                input logic [CNT_W-1:0] cnt);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_kind <= kind;
        i_seed_value <= seed;
        i_bit_count <= cnt;
        do begin
            @(negedge i_clk);
            taken = !full;
            @(posedge i_clk);
        end while (!taken);
        predict_request(kind, seed, cnt);
        request_count++;
    endtask

    task automatic wait_all_drawn();
        push <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(negedge i_clk) begin
        t_draw want;
        if (pop && !empty) begin
            if (pending_draws.size() == 0) begin
                report_mismatch("result with no request waiting", int'(o_value), 0);
            end else begin
                want = pending_draws.pop_front();
                checked_count++;
                if (o_value !== want.value)
                    report_mismatch("value", int'(o_value), int'(want.value));
                if (o_in_range !== want.in_range)
                    report_mismatch("in_range", int'(o_in_range), int'(want.in_range));
            end
        end
    end

    task automatic test_directed_corners();
        // first draw after reset refills the reserve
        send_request(KIND_UNSIGNED, 8'h00, 4'd8);
        send_request(KIND_UNSIGNED, 8'hFF, 4'd1);
        send_request(KIND_UNSIGNED, 8'h00, 4'd0);
        send_request(KIND_UNSIGNED, 8'h00, 4'd9);
        send_request(KIND_UNSIGNED, 8'hFF, 4'd15);
        send_request(KIND_SIGNED, 8'h00, 4'd7);
        send_request(KIND_SIGNED, 8'h00, 4'd1);
        send_request(KIND_SIGNED, 8'h00, 4'd0);
        send_request(KIND_SIGNED, 8'h00, 4'd8);
        send_request(KIND_SIGNED, 8'hFF, 4'd15);
        // zero seed is ignored
        send_request(KIND_SEED, 8'h00, 4'd15);
        send_request(KIND_UNSIGNED, 8'h00, 4'd3);
        send_request(KIND_SEED, 8'hFF, 4'd0);
        send_request(KIND_UNSIGNED, 8'h00, 4'd5);
        send_request(KIND_SIGNED, 8'h00, 4'd4);
        send_request(KIND_UNUSED, 8'hFF, 4'd15);
        send_request(KIND_UNSIGNED, 8'h00, 4'd8);
        send_request(KIND_SEED, 8'h80, 4'd7);
        send_request(KIND_SIGNED, 8'h00, 4'd6);
        send_request(KIND_UNSIGNED, 8'h00, 4'd2);
        send_request(KIND_UNSIGNED, 8'h00, 4'd7);
        send_request(KIND_UNUSED, 8'h00, 4'd0);
        send_request(KIND_SEED, 8'h01, 4'd8);
        send_request(KIND_SIGNED, 8'h00, 4'd3);
    endtask

    task automatic test_seeded_streams(input int n_items);
        int         sent;
        int         run_len;
        logic [1:0] kind;
        sent = 0;
        while (sent < n_items) begin
            send_request(KIND_SEED, 8'($urandom_range(255, 1)), 4'($urandom_range(15)));
            run_len = $urandom_range(20, 4);
            repeat (run_len) begin
                kind = $urandom_range(1) ? KIND_SIGNED : KIND_UNSIGNED;
                send_request(kind, 8'($urandom_range(255)),
                             (kind == KIND_SIGNED) ? 4'($urandom_range(MAX_SIGNED, 1))
                                                   : 4'($urandom_range(MAX_UNSIGNED, 1)));
            end
            sent += run_len + 1;
        end
    endtask

    task automatic test_random_mix(input int n_items);
        int                sent;
        int                pick;
        logic [1:0]        kind;
        logic [WORD_W-1:0] seed;
        logic [CNT_W-1:0]  cnt;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            seed = 8'($urandom_range(255));
            if (pick < 10) begin
                kind = KIND_SEED;
                if ($urandom_range(3) == 0)
                    seed = '0;
            end else if (pick < 14) begin
                kind = KIND_UNUSED;
            end else begin
                kind = $urandom_range(1) ? KIND_SIGNED : KIND_UNSIGNED;
            end
            if ($urandom_range(4) == 0)
                cnt = 4'($urandom_range(15));
            else if (kind == KIND_SIGNED)
                cnt = 4'($urandom_range(MAX_SIGNED, 1));
            else
                cnt = 4'($urandom_range(MAX_UNSIGNED, 1));
            send_request(kind, seed, cnt);
            if (kind == KIND_SIGNED || kind == KIND_UNSIGNED || (kind == KIND_SEED && seed != 0))
                sent++;
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        wait_all_drawn();

        send_idle_pct = 33;
        recv_idle_pct <= 81;
        test_seeded_streams(300);
        wait_all_drawn();
        test_random_mix(275);
        wait_all_drawn();

        send_idle_pct = 81;
        recv_idle_pct <= 33;
        test_seeded_streams(300);
        wait_all_drawn();
        test_random_mix(275);
        wait_all_drawn();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        test_seeded_streams(300);
        wait_all_drawn();
        test_random_mix(275);
        wait_all_drawn();

        $display("%0d requests sent: %0d seeds, %0d draws (%0d out of range)",
                 request_count, seed_count, draw_count, range_err_count);
        $display("%0d results checked over three sender/receiver stall mixes",
                 checked_count);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/xbd_pkg.sv
hdl/xbd_front.sv
hdl/xbd_cmd_fifo.sv
hdl/xbd_back.sv
hdl/xorshift8_bit_dispenser_top.sv
tb/sv/tb_xorshift8_bit_dispenser_top.sv
